### hw/rtl/pmrf_pkg.sv
// shared types and constants of the potts mrf metropolis voxel update block
// no dependencies; used by pmrf_ctrl, pmrf_dpath and the top level
package pmrf_pkg;

    // fixed field widths
    localparam int COORD_W   = 6;
    localparam int LBL_F_W   = 8;
    localparam int WEIGHT_W  = 16;
    localparam int SIZE_W    = 7;
    localparam int NLBL_W    = 9;
    localparam int UNI_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int STEP_W    = 3;

    // signed energy width: |alpha| + 6 * |beta| fits
    localparam int ENERGY_W  = 21;
    // stored probability, one above the 16-bit uniform range
    localparam int PROB_W    = 17;

    // round(2^32 * exp(-1/256))
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;

    // action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LABELS = 3'd5;

    // read steps: centre, then x-1, x+1, y-1, y+1, z-1, z+1
    localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_XM     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_XP     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_YM     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_YP     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_ZM     = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ZP     = 3'd6;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_WAIT,
        ST_ENERGY,
        ST_EXP,
        ST_DECIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              fill_en;
        logic              capture;
        logic              rd_en;
        logic [STEP_W-1:0] step;
        logic              lbl_we;
        logic              energy_en;
        logic              decide;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic       fill_last;
        logic [1:0] act;
        logic       in_vol;
        logic       do_update;
        logic       take;
        logic       out_free;
    } t_stat;

endpackage

### hw/rtl/pmrf_ram.sv
// generic single-port ram with registered read data
// no dependencies
module pmrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pmrf_ctrl.sv
// controller state machine: sequences table fill, voxel reads, decision and result
// depends on pmrf_pkg; drives pmrf_dpath through t_cmd, reads t_stat
module pmrf_ctrl
    import pmrf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_step  <= STEP_CENTRE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_FILL: begin
                o_cmd.fill_en = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_step = STEP_CENTRE;
                case (i_stat.act)
                    ACT_LOAD: begin
                        // loads outside the volume are dropped
                        o_cmd.lbl_we = i_stat.in_vol;
                        n_state      = ST_IDLE;
                    end
                    ACT_UPDATE, ACT_READ: begin
                        n_state = i_stat.in_vol ? ST_READ : ST_DONE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.step  = r_step;
                if (!i_stat.do_update || r_step == STEP_ZP) begin
                    n_state = ST_WAIT;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_WAIT: begin
                // last read data lands this cycle
                n_state = i_stat.do_update ? ST_ENERGY : ST_DONE;
            end
            ST_ENERGY: begin
                o_cmd.energy_en = 1'b1;
                n_state         = ST_EXP;
            end
            ST_EXP: begin
                // probability table read in flight
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                o_cmd.lbl_we = i_stat.take;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### hw/rtl/pmrf_dpath.sv
// datapath: configuration registers, label volume, probability table, energy and result
// depends on pmrf_pkg and pmrf_ram; controlled by pmrf_ctrl through t_cmd
module pmrf_dpath
    import pmrf_pkg::*;
#(
    parameter int MAX_DIM         = 64,
    parameter int LABEL_BITS      = 8,
    parameter int EXP_TABLE_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [1:0]           i_action,
    input  logic [COORD_W-1:0]   i_pos_x,
    input  logic [COORD_W-1:0]   i_pos_y,
    input  logic [COORD_W-1:0]   i_pos_z,
    input  logic [LBL_F_W-1:0]   i_load_label,
    input  logic [LBL_F_W-1:0]   i_group_label,
    input  logic                 i_in_mask,
    input  logic [LBL_F_W-1:0]   i_candidate,
    input  logic [UNI_W-1:0]     i_uniform,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [LBL_F_W-1:0]   o_label_out,
    output logic                 o_accepted,
    output logic                 o_out_of_range
);

    localparam int AW    = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
    localparam int XW    = $clog2(EXP_TABLE_DEPTH);
    localparam int EXT_W = 9;
    localparam int NC_W  = COORD_W + 1;
    localparam logic [EXT_W-1:0] DIM_LIM = EXT_W'(MAX_DIM);

    // configuration
    logic [WEIGHT_W-1:0] r_alpha, r_beta;
    logic [SIZE_W-1:0]   r_size_x, r_size_y, r_size_z;
    logic [NLBL_W-1:0]   r_num_labels;

    // captured transaction
    logic [1:0]         r_act;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [LBL_F_W-1:0] r_ld, r_grp, r_cand;
    logic               r_mask;
    logic [UNI_W-1:0]   r_uni;

    // read pipeline and accumulators
    logic                  r_p_en, r_p_nbv;
    logic [STEP_W-1:0]     r_p_step;
    logic [LABEL_BITS-1:0] r_cur;
    logic signed [3:0]     r_dl;
    logic signed [ENERGY_W-1:0] r_e;
    logic                  r_take;

    // probability table fill
    logic [32:0]   r_exp_r, n_exp_r;
    logic [XW-1:0] r_fill_addr;
    logic [63:0]   exp_prod;

    // output register
    logic               r_out_valid;
    logic [LBL_F_W-1:0] r_label_out;
    logic               r_accepted, r_oor;

    logic [EXT_W-1:0] ext_x, ext_y, ext_z;
    logic             in_vol, do_update, take, nb_valid;
    logic [NC_W-1:0]  nx, ny, nz;
    logic [AW-1:0]    lbl_addr;
    logic [LABEL_BITS-1:0] lbl_wdata, lbl_rdata;
    logic [XW-1:0]    exp_addr;
    logic [PROB_W-1:0] exp_wdata, exp_rdata;
    logic             ne_cand, ne_cur, ne_cg, ne_ug;
    logic signed [ENERGY_W-1:0] beta_s, dl_s, alpha_term, e_next;

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [SIZE_W-1:0] s);
        logic [EXT_W-1:0] sw;
        sw = EXT_W'(s);
        return (sw > DIM_LIM) ? DIM_LIM : sw;
    endfunction

    function automatic logic [AW-1:0] vox_addr(input logic [NC_W-1:0] x,
                                               input logic [NC_W-1:0] y,
                                               input logic [NC_W-1:0] z);
        logic [31:0] a;
        a = 32'(x) + 32'(MAX_DIM) * 32'(y) + 32'(MAX_DIM * MAX_DIM) * 32'(z);
        return a[AW-1:0];
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= 16'd256;
            r_beta       <= 16'd256;
            r_size_x     <= 7'd64;
            r_size_y     <= 7'd64;
            r_size_z     <= 7'd64;
            r_num_labels <= 9'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ALPHA:      r_alpha      <= i_cfg_data;
                REG_BETA:       r_beta       <= i_cfg_data;
                REG_SIZE_X:     r_size_x     <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:     r_size_y     <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:     r_size_z     <= i_cfg_data[SIZE_W-1:0];
                REG_NUM_LABELS: r_num_labels <= i_cfg_data[NLBL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_ld   <= i_load_label;
            r_grp  <= i_group_label;
            r_mask <= i_in_mask;
            r_cand <= i_candidate;
            r_uni  <= i_uniform;
        end
    end

    assign ext_x  = clamp_ext(r_size_x);
    assign ext_y  = clamp_ext(r_size_y);
    assign ext_z  = clamp_ext(r_size_z);
    assign in_vol = (EXT_W'(r_x) < ext_x) && (EXT_W'(r_y) < ext_y) && (EXT_W'(r_z) < ext_z);

    assign do_update = (r_act == ACT_UPDATE) && r_mask
                       && (NLBL_W'(r_cand) < r_num_labels)
                       && (LBL_F_W'(r_cand >> LABEL_BITS) == '0);

    // ---------------------------------------------------------------- neighbour address
    always_comb begin
        nx       = NC_W'(r_x);
        ny       = NC_W'(r_y);
        nz       = NC_W'(r_z);
        nb_valid = 1'b1;
        case (i_cmd.step)
            STEP_XM: begin
                nx       = NC_W'(r_x) - 7'd1;
                nb_valid = (r_x != '0);
            end
            STEP_XP: begin
                nx       = NC_W'(r_x) + 7'd1;
                nb_valid = (EXT_W'(nx) < ext_x);
            end
            STEP_YM: begin
                ny       = NC_W'(r_y) - 7'd1;
                nb_valid = (r_y != '0);
            end
            STEP_YP: begin
                ny       = NC_W'(r_y) + 7'd1;
                nb_valid = (EXT_W'(ny) < ext_y);
            end
            STEP_ZM: begin
                nz       = NC_W'(r_z) - 7'd1;
                nb_valid = (r_z != '0);
            end
            STEP_ZP: begin
                nz       = NC_W'(r_z) + 7'd1;
                nb_valid = (EXT_W'(nz) < ext_z);
            end
            default: ;
        endcase
    end

    assign lbl_addr  = vox_addr(nx, ny, nz);
    assign lbl_wdata = (r_act == ACT_LOAD) ? r_ld[LABEL_BITS-1:0] : r_cand[LABEL_BITS-1:0];

    pmrf_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (MAX_DIM * MAX_DIM * MAX_DIM)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.lbl_we),
        .i_addr  (lbl_addr),
        .i_wdata (lbl_wdata),
        .o_rdata (lbl_rdata)
    );

    // ---------------------------------------------------------------- read return
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_en <= 1'b0;
        end else begin
            r_p_en <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_step <= i_cmd.step;
        r_p_nbv  <= nb_valid;
    end

    assign ne_cand = (r_cand != LBL_F_W'(lbl_rdata));
    assign ne_cur  = (r_cur != lbl_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dl <= '0;
        end else if (r_p_en) begin
            if (r_p_step == STEP_CENTRE) begin
                r_cur <= lbl_rdata;
            end else if (r_p_nbv) begin
                // outside neighbours contribute nothing
                r_dl <= r_dl + 4'(ne_cand) - 4'(ne_cur);
            end
        end
    end

    // ---------------------------------------------------------------- energy
    assign ne_cg  = (r_cand != r_grp);
    assign ne_ug  = (r_grp != LBL_F_W'(r_cur));
    assign beta_s = ENERGY_W'(r_beta);
    assign dl_s   = {{(ENERGY_W-4){r_dl[3]}}, r_dl};

    always_comb begin
        alpha_term = '0;
        if (ne_cg && !ne_ug) begin
            alpha_term = ENERGY_W'(r_alpha);
        end else if (!ne_cg && ne_ug) begin
            alpha_term = -ENERGY_W'(r_alpha);
        end
    end

    assign e_next = alpha_term + beta_s * dl_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.energy_en) begin
            r_e <= e_next;
        end
    end

    // ---------------------------------------------------------------- probability table
    // p[k] = round(r[k] / 2^16), r[k+1] = round(r[k] * c / 2^32), r[0] = 2^32
    assign exp_prod  = 64'(r_exp_r[31:0]) * 64'(EXP_STEP_Q32);
    assign exp_wdata = PROB_W'((r_exp_r + 33'd32768) >> 16);

    always_comb begin
        if (r_exp_r[32]) begin
            n_exp_r = 33'(EXP_STEP_Q32);
        end else begin
            n_exp_r = 33'((exp_prod + 64'h8000_0000) >> 32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_r     <= 33'h1_0000_0000;
            r_fill_addr <= '0;
        end else if (i_cmd.fill_en) begin
            r_exp_r     <= n_exp_r;
            r_fill_addr <= r_fill_addr + XW'(1);
        end
    end

    assign exp_addr = i_cmd.fill_en ? r_fill_addr : r_e[XW-1:0];

    pmrf_ram #(
        .WIDTH (PROB_W),
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_en),
        .i_addr  (exp_addr),
        .i_wdata (exp_wdata),
        .o_rdata (exp_rdata)
    );

    // energies at or past the table end never pass
    assign take = (r_e <= 0)
                  || ((r_e < ENERGY_W'(EXP_TABLE_DEPTH)) && (PROB_W'(r_uni) < exp_rdata));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_take <= 1'b0;
        end else if (i_cmd.decide) begin
            r_take <= take;
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oor      <= !in_vol;
            r_accepted <= in_vol && r_take;
            if (!in_vol) begin
                r_label_out <= '0;
            end else if (r_take) begin
                r_label_out <= r_cand;
            end else begin
                r_label_out <= LBL_F_W'(r_cur);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_label_out    = r_label_out;
    assign o_accepted     = r_accepted;
    assign o_out_of_range = r_oor;

    assign o_stat.fill_last = (r_fill_addr == XW'(EXP_TABLE_DEPTH - 1));
    assign o_stat.act       = r_act;
    assign o_stat.in_vol    = in_vol;
    assign o_stat.do_update = do_update;
    assign o_stat.take      = take;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

endmodule

### hw/rtl/potts_mrf_metropolis_voxel_update_top.sv
// top level of the potts mrf metropolis voxel update block
// depends on pmrf_pkg, pmrf_ctrl, pmrf_dpath (which holds the pmrf_ram instances)
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    action, pos_x/y/z, load_label, group_label,
//                                                 in_mask, candidate, uniform
// out       output     o_out_valid / i_out_stall  label_out, accepted, out_of_range
// cfg       input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// one transaction at a time; an update makes seven reads, of the centre and its neighbours,
// through the single label memory port
// after reset all EXP_TABLE_DEPTH probability table entries are filled while o_in_stall is high
// the result sits in an output register; a finished transaction waits there while stalled
module potts_mrf_metropolis_voxel_update_top
    import pmrf_pkg::*;
#(
    parameter int MAX_DIM         = 64,
    parameter int LABEL_BITS      = 8,
    parameter int EXP_TABLE_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [COORD_W-1:0]   i_pos_x,
    input  logic [COORD_W-1:0]   i_pos_y,
    input  logic [COORD_W-1:0]   i_pos_z,
    input  logic [LBL_F_W-1:0]   i_load_label,
    input  logic [LBL_F_W-1:0]   i_group_label,
    input  logic                 i_in_mask,
    input  logic [LBL_F_W-1:0]   i_candidate,
    input  logic [UNI_W-1:0]     i_uniform,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LBL_F_W-1:0]   o_label_out,
    output logic                 o_accepted,
    output logic                 o_out_of_range,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    pmrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pmrf_dpath #(
        .MAX_DIM         (MAX_DIM),
        .LABEL_BITS      (LABEL_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_load_label   (i_load_label),
        .i_group_label  (i_group_label),
        .i_in_mask      (i_in_mask),
        .i_candidate    (i_candidate),
        .i_uniform      (i_uniform),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_label_out    (o_label_out),
        .o_accepted     (o_accepted),
        .o_out_of_range (o_out_of_range)
    );

endmodule
